### rtl/vct_pkg.sv
// ----------------------------------------------------------------------------
// vct_pkg
// Shared types for the vector clock table: operation codes and the request
// and response items that travel on the two channels.
// ----------------------------------------------------------------------------
`default_nettype none

package vct_pkg;

  localparam int KEY_W  = 64;
  localparam int TIME_W = 64;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_SET   = 2'd1,
    OP_MERGE = 2'd2,
    OP_QUERY = 2'd3
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [KEY_W-1:0]  key;
    logic [TIME_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [TIME_W-1:0] time_now;
    logic              found;
    logic              table_full;
    logic [TIME_W-1:0] latest_time;
  } rsp_t;

endpackage

`default_nettype wire

### rtl/vector_clock_table.sv
// ----------------------------------------------------------------------------
// vector_clock_table
// One vector clock held as a table of process keys and 64-bit logical times,
// with tick, set, merge and query operations and a running maximum time.
// ----------------------------------------------------------------------------
// Usage
//   Requests arrive on req (req_valid / req_stall) and carry an operation, a
//   process key and a time value. Each accepted item produces exactly one
//   response on rsp (rsp_valid / rsp_stall), in request order.
//   An item is accepted at a rising edge where valid is high and stall low.
//   An accepted item passes the input register, the execute stage, the max
//   tree stages and the response register in turn. Throughput is one item
//   per cycle while rsp_stall is low: key lookup and table update are done
//   in the execute stage, and the largest time over the table is found by
//   a registered max tree, one level per stage: depth sets latency, not rate.
//   Reset (rst, synchronous) empties the table and drops all items in flight;
//   key and time storage is not cleared, only the valid bits.
//   When the receiver stalls, the response register holds its item and the
//   pipeline behind it keeps filling its empty stages; req_stall rises only
//   once every stage holds an item.
// ----------------------------------------------------------------------------
`default_nettype none

module vector_clock_table #(
  parameter int ENTRIES = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  vct_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output vct_pkg::rsp_t rsp
);

  import vct_pkg::*;

  // Depth of the max tree, and the leaf count padded to a power of two.
  localparam int LVLS   = $clog2(ENTRIES);
  localparam int LEAVES = 1 << LVLS;

  // Per-item result fields that ride along with the max tree.
  typedef struct packed {
    logic [TIME_W-1:0] time_now;
    logic              found;
    logic              table_full;
  } meta_t;

  // Table storage. Only the valid bits are reset; a key or time is never
  // looked at while its valid bit is clear.
  logic [ENTRIES-1:0] entry_valid;
  logic [KEY_W-1:0]   entry_key  [ENTRIES];
  logic [TIME_W-1:0]  entry_time [ENTRIES];

  // Input register.
  logic in_vld;
  req_t in_req;

  // Execute stage output: the item's own result, table already updated.
  logic  x_vld;
  meta_t x_meta;

  // Max tree stages, level 0 fed from the table.
  logic [LVLS-1:0] lv_vld;
  meta_t           lv_meta [LVLS];
  logic [LVLS-1:0] lv_rdy;
  logic [TIME_W-1:0] node [1:LEAVES-1];
  logic [TIME_W-1:0] leaf [LEAVES];

  logic in_rdy;
  logic x_rdy;
  logic o_rdy;
  logic exec;

  // Lookup and update logic.
  logic [ENTRIES-1:0] match;
  logic [ENTRIES-1:0] free_oh;
  logic               hit;
  logic               has_free;
  logic               want_ins;
  logic               do_ins;
  logic [TIME_W-1:0]  hit_time;
  logic [TIME_W-1:0]  new_time;
  meta_t              x_meta_next;

  // --------------------------------------------------------------------------
  // Pipeline flow. Each stage loads when it is empty or its item moves on,
  // so bubbles are squeezed out while the output is stalled.
  // --------------------------------------------------------------------------
  assign o_rdy = !rsp_valid || !rsp_stall;

  always_comb begin
    lv_rdy[LVLS-1] = !lv_vld[LVLS-1] || o_rdy;
    for (int l = LVLS - 2; l >= 0; l--) begin
      lv_rdy[l] = !lv_vld[l] || lv_rdy[l+1];
    end
  end

  assign x_rdy     = !x_vld || lv_rdy[0];
  assign in_rdy    = !in_vld || x_rdy;
  assign exec      = in_vld && x_rdy;
  assign req_stall = !in_rdy;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld    <= 1'b0;
      x_vld     <= 1'b0;
      lv_vld    <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (in_rdy) begin
        in_vld <= req_valid;
      end
      if (x_rdy) begin
        x_vld <= in_vld;
      end
      if (lv_rdy[0]) begin
        lv_vld[0] <= x_vld;
      end
      for (int l = 1; l < LVLS; l++) begin
        if (lv_rdy[l]) begin
          lv_vld[l] <= lv_vld[l-1];
        end
      end
      if (o_rdy) begin
        rsp_valid <= lv_vld[LVLS-1];
      end
    end
  end

  // Payload registers along the pipeline.
  always_ff @(posedge clk) begin
    if (in_rdy) begin
      in_req <= req;
    end
    if (x_rdy) begin
      x_meta <= x_meta_next;
    end
    if (lv_rdy[0]) begin
      lv_meta[0] <= x_meta;
    end
    for (int l = 1; l < LVLS; l++) begin
      if (lv_rdy[l]) begin
        lv_meta[l] <= lv_meta[l-1];
      end
    end
    if (o_rdy) begin
      rsp.time_now    <= lv_meta[LVLS-1].time_now;
      rsp.found       <= lv_meta[LVLS-1].found;
      rsp.table_full  <= lv_meta[LVLS-1].table_full;
      rsp.latest_time <= node[1];
    end
  end

  // --------------------------------------------------------------------------
  // Execute: parallel key compare over all slots, lowest free slot by the
  // two's complement trick, and the new time for the slot that is touched.
  // Keys are unique in the table, so at most one slot matches.
  // --------------------------------------------------------------------------
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match[i] = entry_valid[i] && (entry_key[i] == in_req.key);
    end
  end

  always_comb begin
    hit_time = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_time = hit_time | (match[i] ? entry_time[i] : '0);
    end
  end

  assign hit      = |match;
  assign free_oh  = ~entry_valid & (entry_valid + ENTRIES'(1));
  assign has_free = !(&entry_valid);
  assign want_ins = !hit && (in_req.op != OP_QUERY);
  assign do_ins   = want_ins && has_free;

  always_comb begin
    if (hit) begin
      unique case (in_req.op)
        OP_TICK:  new_time = hit_time + TIME_W'(1);
        OP_SET:   new_time = in_req.value;
        OP_MERGE: new_time = (hit_time < in_req.value) ? in_req.value : hit_time;
        OP_QUERY: new_time = hit_time;
        default:  new_time = hit_time;
      endcase
    end else begin
      // A fresh tick starts from zero and lands on one.
      new_time = (in_req.op == OP_TICK) ? TIME_W'(1) : in_req.value;
    end
  end

  always_comb begin
    x_meta_next.time_now   = (hit || do_ins) ? new_time : '0;
    x_meta_next.found      = hit;
    x_meta_next.table_full = want_ins && !has_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (exec && do_ins) begin
      entry_valid <= entry_valid | free_oh;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (match[i] && (in_req.op != OP_QUERY)) begin
          entry_time[i] <= new_time;
        end else if (do_ins && free_oh[i]) begin
          entry_key[i]  <= in_req.key;
          entry_time[i] <= new_time;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Max tree. Level 0 samples the table when the item in the execute stage
  // moves on; the table then still holds exactly that item's result, since
  // the next item's update lands on the same edge. Nodes are heap indexed:
  // node 1 is the root, children of j are 2j and 2j+1.
  // --------------------------------------------------------------------------
  for (genvar i = 0; i < LEAVES; i++) begin : g_leaf
    if (i < ENTRIES) begin : g_used
      assign leaf[i] = entry_valid[i] ? entry_time[i] : '0;
    end else begin : g_pad
      assign leaf[i] = '0;
    end
  end

  for (genvar j = 1; j < LEAVES; j++) begin : g_node
    localparam int L = LVLS - $clog2(j + 1);
    if (L == 0) begin : g_bottom
      always_ff @(posedge clk) begin
        if (lv_rdy[L]) begin
          node[j] <= (leaf[2*j-LEAVES] > leaf[2*j+1-LEAVES]) ?
                     leaf[2*j-LEAVES] : leaf[2*j+1-LEAVES];
        end
      end
    end else begin : g_inner
      always_ff @(posedge clk) begin
        if (lv_rdy[L]) begin
          node[j] <= (node[2*j] > node[2*j+1]) ? node[2*j] : node[2*j+1];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_one_match: assert property (@(posedge clk) disable iff (rst)
    in_vld |-> $onehot0(match))
    else $error("more than one slot holds the same key");

  a_full_no_write: assert property (@(posedge clk) disable iff (rst)
    exec && want_ins && !has_free |=> entry_valid == $past(entry_valid))
    else $error("refused insert changed the table");

  a_full_result: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.table_full |-> !rsp.found && (rsp.time_now == '0))
    else $error("refused insert reported a time or a hit");

  a_latest_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.latest_time >= rsp.time_now)
    else $error("latest time below the entry's own time");

endmodule

`default_nettype wire
